// File: hdl/sgw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgw_pkg: shared constants for the Savitzky-Golay window filter
// Mode codes, kernel taps, divisors and job descriptor type.
// ----------------------------------------------------------------------------
package sgw_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int WIN_LEN          = 9;
    localparam int TAIL_LEN         = 4;
    localparam int DEN_W            = 9;

    // Kernel select codes (the unused code behaves as smoothing)
    localparam logic [1:0] MODE_DERIV5  = 2'd0;
    localparam logic [1:0] MODE_SMOOTH7 = 2'd1;
    localparam logic [1:0] MODE_DERIV9  = 2'd2;

    localparam logic [3:0] SEEN_MAX = 4'd9;

    // Kernel divisors
    localparam int DEN_5PT = 7;
    localparam int DEN_7PT = 21;
    localparam int DEN_9PT = 462;

    // Taps, window entry 0 newest, zero padded to the window length
    localparam logic signed [5:0] TAPS_D5 [WIN_LEN] = '{
        6'sd2, -6'sd1, -6'sd2, -6'sd1, 6'sd2, 6'sd0, 6'sd0, 6'sd0, 6'sd0
    };
    localparam logic signed [5:0] TAPS_S7 [WIN_LEN] = '{
        -6'sd2, 6'sd3, 6'sd6, 6'sd7, 6'sd6, 6'sd3, -6'sd2, 6'sd0, 6'sd0
    };
    localparam logic signed [5:0] TAPS_D9 [WIN_LEN] = '{
        6'sd28, 6'sd7, -6'sd8, -6'sd17, -6'sd20, -6'sd17, -6'sd8, 6'sd7, 6'sd28
    };

    // Per-request control that travels down the pipeline
    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] half;
        logic       last;
        logic       head_en;
        logic       use_filt;
        logic [1:0] tail_ptr;
    } sgw_job_t;

    function automatic logic [2:0] half_width(input logic [1:0] mode);
        case (mode)
            MODE_DERIV5: return 3'd2;
            MODE_DERIV9: return 3'd4;
            default:     return 3'd3;
        endcase
    endfunction

    function automatic logic signed [5:0] tap(input logic [1:0] mode, input logic [3:0] k);
        case (mode)
            MODE_DERIV5: return TAPS_D5[k];
            MODE_DERIV9: return TAPS_D9[k];
            default:     return TAPS_S7[k];
        endcase
    endfunction

    function automatic logic [DEN_W-1:0] den(input logic [1:0] mode);
        case (mode)
            MODE_DERIV5: return DEN_W'(DEN_5PT);
            MODE_DERIV9: return DEN_W'(DEN_9PT);
            default:     return DEN_W'(DEN_7PT);
        endcase
    endfunction

    // Rounding offset, half the divisor
    function automatic logic [7:0] half_den(input logic [1:0] mode);
        case (mode)
            MODE_DERIV5: return 8'(DEN_5PT / 2);
            MODE_DERIV9: return 8'(DEN_9PT / 2);
            default:     return 8'(DEN_7PT / 2);
        endcase
    endfunction

endpackage
`default_nettype wire

// File: hdl/savitzky_golay_window_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// savitzky_golay_window_filter: streaming quadratic Savitzky-Golay filter
// Nine-sample window, three fixed kernels, round to nearest, saturate,
// pass-through of spectrum edges and tail flush on the last sample.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  tdata: sample_in; tlast: last_in
// m_*       out  m_tvalid/m_tready  tdata: sample_out; tlast: last_out
// cfg_*     in   cfg_wr_en          cfg_wr_data: window_mode
//
// One request per cycle in steady state, while s_tready is high; the first
// result of a request is offered from the output register after the window
// snapshot, kernel sum, rounding and a two-digit divide by the kernel
// constant with a multiply and correct each.
// A last request yields up to five results, one per cycle from the output
// stage while m_tready is high; s_tready drops while the last pipe stage
// holds a request and the output stage still has results left to send.
// Reset (aresetn low, synchronous) clears the pipe, the sample count and
// selects seven-point smoothing.
// ----------------------------------------------------------------------------
module savitzky_golay_window_filter #(
    parameter int SAMPLE_WIDTH = sgw_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                                         aclk,
    input  wire                                         aresetn,
    input  wire                                         cfg_wr_en,
    input  wire  [1:0]                                  cfg_wr_data,  // window_mode
    input  wire                                         s_tvalid,
    output logic                                        s_tready,
    input  wire  [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   s_tdata,      // sample_in
    input  wire                                         s_tlast,
    output logic                                        m_tvalid,
    input  wire                                         m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   m_tdata,      // sample_out
    output logic                                        m_tlast
);

    localparam int W       = SAMPLE_WIDTH;
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int NWIN    = sgw_pkg::WIN_LEN;
    localparam int NTAIL   = sgw_pkg::TAIL_LEN;
    localparam int DEN_W   = sgw_pkg::DEN_W;
    localparam int ACC_W   = W + 8;
    localparam int MAG_W   = W + 7;
    localparam int LO_W    = MAG_W / 2;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int REC_S   = LO_W + DEN_W;
    localparam int PAY_W   = (NTAIL + 1) * W;

    localparam logic [REC_S-1:0] REC_D5 = REC_S'((64'd1 << REC_S) / sgw_pkg::DEN_5PT);
    localparam logic [REC_S-1:0] REC_D7 = REC_S'((64'd1 << REC_S) / sgw_pkg::DEN_7PT);
    localparam logic [REC_S-1:0] REC_D9 = REC_S'((64'd1 << REC_S) / sgw_pkg::DEN_9PT);

    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (W - 1));

    function automatic logic [REC_S-1:0] recip(input logic [1:0] mode);
        case (mode)
            sgw_pkg::MODE_DERIV5: return REC_D5;
            sgw_pkg::MODE_DERIV9: return REC_D9;
            default:              return REC_D7;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]             mode_reg;
    logic [3:0]             seen_reg;
    logic [W-1:0]           win_reg  [NWIN-1];
    logic [W-1:0]           win1_reg [NWIN];
    logic [7:1]             vld_reg;
    sgw_pkg::sgw_job_t      job_reg  [1:7];
    logic [PAY_W-1:0]       pay_reg  [2:7];
    logic [7:3]             neg_reg;

    logic signed [ACC_W-1:0] acc2_reg;
    logic [MAG_W-1:0]       mag3_reg;
    logic [HI_W-1:0]        qhe4_reg;
    logic [HI_W-1:0]        xh4_reg;
    logic [LO_W-1:0]        xl4_reg;
    logic [HI_W-1:0]        qh5_reg;
    logic [DEN_W-1:0]       rh5_reg;
    logic [LO_W-1:0]        xl5_reg;
    logic [HI_W-1:0]        qh6_reg;
    logic [LO_W-1:0]        qle6_reg;
    logic [REC_S-1:0]       y6_reg;
    logic [MAG_W-1:0]       q7_reg;

    logic [W-1:0]           em_head_reg;
    logic                   em_head_pend_reg;
    logic [W-1:0]           em_tail_reg [NTAIL];
    logic                   em_tail_act_reg;
    logic [1:0]             em_ptr_reg;

    // ------------------------------------------------------------------
    // Handshake and flow control
    // ------------------------------------------------------------------
    logic em_valid, em_take, em_final, em_free, pipe_en, s_acc;

    assign em_valid = em_head_pend_reg || em_tail_act_reg;
    assign em_take  = em_valid && m_tready;
    assign em_final = em_head_pend_reg ? !em_tail_act_reg : (em_ptr_reg == 2'd0);
    assign em_free  = !em_valid || (em_take && em_final);
    assign pipe_en  = !vld_reg[7] || em_free;
    assign s_tready = pipe_en;
    assign s_acc    = s_tvalid && pipe_en;

    // ------------------------------------------------------------------
    // Request decode at acceptance
    // ------------------------------------------------------------------
    logic [2:0]        acc_half;
    sgw_pkg::sgw_job_t job1_next;
    logic [3:0]        seen_next;

    always_comb begin
        acc_half           = sgw_pkg::half_width(mode_reg);
        job1_next.mode     = mode_reg;
        job1_next.half     = acc_half;
        job1_next.last     = s_tlast;
        job1_next.head_en  = seen_reg >= {1'b0, acc_half};
        job1_next.use_filt = seen_reg >= {acc_half, 1'b0};
        job1_next.tail_ptr = job1_next.head_en ? 2'(acc_half - 3'd1) : seen_reg[1:0];
        if (s_tlast) begin
            seen_next = 4'd0;
        end else if (seen_reg < sgw_pkg::SEEN_MAX) begin
            seen_next = seen_reg + 4'd1;
        end else begin
            seen_next = seen_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: kernel sum and pass-through values
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc2_next;
    logic [PAY_W-1:0]        pay2_next;

    always_comb begin
        acc2_next = '0;
        for (int k = 0; k < NWIN; k++) begin
            acc2_next = acc2_next
                + ACC_W'(sgw_pkg::tap(job_reg[1].mode, 4'(k)))
                * ACC_W'($signed(win1_reg[k]));
        end
        pay2_next[W-1:0] = win1_reg[{1'b0, job_reg[1].half}];
        for (int k = 0; k < NTAIL; k++) begin
            pay2_next[(k + 1) * W +: W] = win1_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitude plus rounding offset
    // ------------------------------------------------------------------
    logic             neg3_next;
    logic [ACC_W-1:0] abs3;
    logic [MAG_W-1:0] mag3_next;

    always_comb begin
        neg3_next = acc2_reg[ACC_W-1];
        abs3      = neg3_next ? ACC_W'(-acc2_reg) : ACC_W'(acc2_reg);
        mag3_next = abs3[MAG_W-1:0] + MAG_W'(sgw_pkg::half_den(job_reg[2].mode));
    end

    // ------------------------------------------------------------------
    // Stage 4: high digit quotient estimate
    // ------------------------------------------------------------------
    logic [HI_W+REC_S-1:0] prod4;
    logic [HI_W-1:0]       qhe4_next;

    always_comb begin
        prod4     = (HI_W + REC_S)'(mag3_reg[MAG_W-1:LO_W])
                  * (HI_W + REC_S)'(recip(job_reg[3].mode));
        qhe4_next = prod4[REC_S +: HI_W];
    end

    // ------------------------------------------------------------------
    // Stage 5: high digit correction and remainder
    // ------------------------------------------------------------------
    logic [DEN_W-1:0]      den5;
    logic [HI_W+DEN_W-1:0] back5, diff5;
    logic [DEN_W:0]        rem5;
    logic [HI_W-1:0]       qh5_next;
    logic [DEN_W-1:0]      rh5_next;

    always_comb begin
        den5  = sgw_pkg::den(job_reg[4].mode);
        back5 = (HI_W + DEN_W)'(qhe4_reg) * (HI_W + DEN_W)'(den5);
        diff5 = (HI_W + DEN_W)'(xh4_reg) - back5;
        rem5  = diff5[DEN_W:0];
        if (rem5 >= {1'b0, den5}) begin
            qh5_next = qhe4_reg + HI_W'(1);
            rh5_next = DEN_W'(rem5 - {1'b0, den5});
        end else begin
            qh5_next = qhe4_reg;
            rh5_next = rem5[DEN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: low digit quotient estimate
    // ------------------------------------------------------------------
    logic [REC_S-1:0]   y6_next;
    logic [2*REC_S-1:0] prod6;
    logic [LO_W-1:0]    qle6_next;

    always_comb begin
        y6_next   = {rh5_reg, xl5_reg};
        prod6     = (2 * REC_S)'(y6_next) * (2 * REC_S)'(recip(job_reg[5].mode));
        qle6_next = prod6[REC_S +: LO_W];
    end

    // ------------------------------------------------------------------
    // Stage 7: low digit correction
    // ------------------------------------------------------------------
    logic [DEN_W-1:0] den7;
    logic [REC_S-1:0] back7, diff7;
    logic [DEN_W:0]   rem7;
    logic [LO_W-1:0]  ql7;

    always_comb begin
        den7  = sgw_pkg::den(job_reg[6].mode);
        back7 = REC_S'(qle6_reg) * REC_S'(den7);
        diff7 = y6_reg - back7;
        rem7  = diff7[DEN_W:0];
        ql7   = (rem7 >= {1'b0, den7}) ? qle6_reg + LO_W'(1) : qle6_reg;
    end

    // ------------------------------------------------------------------
    // Output stage load: sign, saturation, head select
    // ------------------------------------------------------------------
    logic [W-1:0] filt_val, head_val;

    always_comb begin
        if (!neg_reg[7]) begin
            filt_val = (q7_reg > POS_LIM) ? {1'b0, {(W - 1){1'b1}}} : q7_reg[W-1:0];
        end else begin
            filt_val = (q7_reg > NEG_LIM) ? {1'b1, {(W - 1){1'b0}}}
                                          : W'(~q7_reg[W-1:0] + W'(1));
        end
        head_val = job_reg[7].use_filt ? filt_val : pay_reg[7][W-1:0];
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= sgw_pkg::MODE_SMOOTH7;
            seen_reg         <= 4'd0;
            vld_reg          <= '0;
            em_head_pend_reg <= 1'b0;
            em_tail_act_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (s_acc) begin
                seen_reg <= seen_next;
            end
            if (pipe_en) begin
                vld_reg <= {vld_reg[6:1], s_acc};
            end
            if (vld_reg[7] && em_free) begin
                em_head_pend_reg <= job_reg[7].head_en;
                em_tail_act_reg  <= job_reg[7].last;
            end else if (em_take) begin
                if (em_head_pend_reg) begin
                    em_head_pend_reg <= 1'b0;
                end else if (em_ptr_reg == 2'd0) begin
                    em_tail_act_reg <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        // sample history shifts on every accepted request
        if (s_acc) begin
            win_reg[0] <= s_tdata[W-1:0];
            for (int k = 1; k < NWIN - 1; k++) begin
                win_reg[k] <= win_reg[k - 1];
            end
        end
        if (pipe_en) begin
            if (s_acc) begin
                win1_reg[0] <= s_tdata[W-1:0];
                for (int k = 1; k < NWIN; k++) begin
                    win1_reg[k] <= win_reg[k - 1];
                end
                job_reg[1] <= job1_next;
            end
            for (int s = 2; s <= 7; s++) begin
                job_reg[s] <= job_reg[s - 1];
            end
            pay_reg[2] <= pay2_next;
            for (int s = 3; s <= 7; s++) begin
                pay_reg[s] <= pay_reg[s - 1];
            end
            neg_reg  <= {neg_reg[6:3], neg3_next};
            acc2_reg <= acc2_next;
            mag3_reg <= mag3_next;
            qhe4_reg <= qhe4_next;
            xh4_reg  <= mag3_reg[MAG_W-1:LO_W];
            xl4_reg  <= mag3_reg[LO_W-1:0];
            qh5_reg  <= qh5_next;
            rh5_reg  <= rh5_next;
            xl5_reg  <= xl4_reg;
            qh6_reg  <= qh5_reg;
            qle6_reg <= qle6_next;
            y6_reg   <= y6_next;
            q7_reg   <= {qh6_reg, ql7};
        end
        // output stage: head first, then the tail newest-last
        if (vld_reg[7] && em_free) begin
            em_head_reg <= head_val;
            em_ptr_reg  <= job_reg[7].tail_ptr;
            for (int k = 0; k < NTAIL; k++) begin
                em_tail_reg[k] <= pay_reg[7][(k + 1) * W +: W];
            end
        end else if (em_take && !em_head_pend_reg && em_ptr_reg != 2'd0) begin
            em_ptr_reg <= em_ptr_reg - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign m_tvalid = em_valid;
    assign m_tdata  = TDATA_W'(em_head_pend_reg ? em_head_reg : em_tail_reg[em_ptr_reg]);
    assign m_tlast  = !em_head_pend_reg && em_tail_act_reg && (em_ptr_reg == 2'd0);

endmodule
`default_nettype wire

// File: tb/sv/sgw_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgw_result_checker: result predictor and scoreboard for the window filter
// Watches the config write, the sample request channel and the result
// channel. Keeps its own kernel mode, nine-sample window and per-spectrum
// sample count, queues the results each accepted request owes, and compares
// every accepted result field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module sgw_result_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                                         aclk,
    input  wire                                         aresetn,
    input  wire                                         cfg_wr_en,
    input  wire  [1:0]                                  cfg_wr_data,  // window_mode
    input  wire                                         s_tvalid,
    input  wire                                         s_tready,
    input  wire  [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   s_tdata,      // sample_in
    input  wire                                         s_tlast,
    input  wire                                         m_tvalid,
    input  wire                                         m_tready,
    input  wire  [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   m_tdata,      // sample_out
    input  wire                                         m_tlast,
    output int                                          mismatch_count,
    output int                                          samples_owed
);

    localparam int WIN_DEPTH = 9;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           last;
    } filt_out_t;

    logic [1:0]                     kernel_mode;
    logic signed [SAMPLE_WIDTH-1:0] window_q [WIN_DEPTH];
    int                             seen_count;
    filt_out_t                      owed_q [$];

    // Half width of the kernel; the spare code smooths
    function automatic int half_of(input logic [1:0] mode);
        case (mode)
            sgw_pkg::MODE_DERIV5: return 2;
            sgw_pkg::MODE_DERIV9: return 4;
            default:              return 3;
        endcase
    endfunction

    // Symmetric taps, indexed by distance from the window center
    function automatic longint coef(input int half, input int k);
        int offset;
        offset = (k > half) ? k - half : half - k;
        case (half)
            2: begin
                case (offset)
                    0:       return -2;
                    1:       return -1;
                    default: return 2;
                endcase
            end
            4: begin
                case (offset)
                    0:       return -20;
                    1:       return -17;
                    2:       return -8;
                    3:       return 7;
                    default: return 28;
                endcase
            end
            default: begin
                case (offset)
                    0:       return 7;
                    1:       return 6;
                    2:       return 3;
                    default: return -2;
                endcase
            end
        endcase
    endfunction

    function automatic longint divisor_of(input int half);
        case (half)
            2:       return 7;
            4:       return 462;
            default: return 21;
        endcase
    endfunction

    // Kernel sum, divide with ties away from zero, clamp to the sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] kernel_output(input int half);
        longint acc;
        longint mag;
        longint quo;
        longint hi;
        longint lo;
        int     k;
        acc = 0;
        for (k = 0; k <= 2 * half; k++)
            acc += coef(half, k) * longint'(window_q[k]);
        mag = (acc < 0) ? -acc : acc;
        quo = (mag + divisor_of(half) / 2) / divisor_of(half);
        if (acc < 0)
            quo = -quo;
        hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (quo > hi)
            quo = hi;
        if (quo < lo)
            quo = lo;
        return quo[SAMPLE_WIDTH-1:0];
    endfunction

    task automatic owe(input logic signed [SAMPLE_WIDTH-1:0] value, input logic last);
        filt_out_t entry;
        entry.value = value;
        entry.last  = last;
        owed_q.insert(owed_q.size(), entry);
    endtask

    // One accepted sample: shift it in and queue what it releases
    task automatic take_sample(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic lst);
        int half;
        int n;
        int k;
        half = half_of(kernel_mode);
        n    = seen_count;
        for (k = WIN_DEPTH - 1; k > 0; k--)
            window_q[k] = window_q[k - 1];
        window_q[0] = smp;

        if (n >= half) begin
            owe((n >= 2 * half) ? kernel_output(half) : window_q[half], 1'b0);
            if (lst) begin
                // tail flush, oldest first
                for (k = half - 1; k >= 0; k--)
                    owe(window_q[k], k == 0);
            end
        end else if (lst) begin
            // short spectrum goes out whole
            for (k = n; k >= 0; k--)
                owe(window_q[k], k == 0);
        end

        if (lst)
            seen_count = 0;
        else if (seen_count < WIN_DEPTH)
            seen_count++;
    endtask

    task automatic check_result(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic lst);
        filt_out_t want;
        if (owed_q.size() == 0) begin
            $error("unexpected result: sample_out %0d last_out %0b", smp, lst);
            mismatch_count++;
        end else begin
            want = owed_q.pop_front();
            if (smp !== want.value) begin
                $error("sample_out: expected %0d, actual %0d", want.value, smp);
                mismatch_count++;
            end
            if (lst !== want.last) begin
                $error("last_out: expected %0b, actual %0b", want.last, lst);
                mismatch_count++;
            end
        end
    endtask

    // Everything is sampled at the edge, before the block updates
    always @(posedge aclk) begin
        if (!aresetn) begin
            kernel_mode    = sgw_pkg::MODE_SMOOTH7;
            seen_count     = 0;
            foreach (window_q[i])
                window_q[i] = '0;
            owed_q.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result($signed(m_tdata[SAMPLE_WIDTH-1:0]), m_tlast);
            if (cfg_wr_en)
                kernel_mode = cfg_wr_data;
            if (s_tvalid && s_tready)
                take_sample($signed(s_tdata[SAMPLE_WIDTH-1:0]), s_tlast);
        end
        samples_owed = owed_q.size();
    end

endmodule

// File: tb/sv/savitzky_golay_window_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// savitzky_golay_window_filter_test: stimulus and verdict for the window filter
// Directed spectra at the sample extremes and edge lengths, then random
// spectra under each kernel mode, with bursty requests, a patterned result
// stall and one long hold-off that backs the pipe up. Checking is done by
// sgw_result_checker beside the block.
// ----------------------------------------------------------------------------
module savitzky_golay_window_filter_test;

    localparam int SAMPLE_WIDTH    = 24;
    localparam int TDATA_W         = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 16;
    localparam int CYCLE_LIMIT     = 200000;

    // Spare mode code, behaves as smoothing
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_e;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [1:0]         cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata     = '0;
    logic               s_tlast     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    int mismatch_count;
    int samples_owed;
    int cycle_count = 0;
    int burst_left  = 0;
    bit flood_phase = 1'b0;

    savitzky_golay_window_filter #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    sgw_result_checker #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .samples_owed   (samples_owed)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("savitzky_golay_window_filter verification failed");
            $finish;
        end
    end

    // Result side: one long hold-off once flooding starts, else stall patterns
    initial begin
        rx_style_e style;
        int        span;
        bit        hold_done;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (flood_phase && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            style = rx_style_e'($urandom_range(0, 3));
            span  = $urandom_range(4, 40);
            repeat (span) begin
                // start the hold-off as soon as flooding begins
                if (flood_phase && !hold_done)
                    break;
                case (style)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Offer one sample; requests come in bursts with random gaps between
    task automatic offer_sample(input logic signed [SAMPLE_WIDTH-1:0] smp, input bit lst);
        int  gap;
        logic rdy;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(smp);
        s_tlast  <= lst;
        // ready is stable by the falling edge and holds through the next rise
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        burst_left--;
    endtask

    // Stop requesting and let every owed result come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (samples_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window_mode(input logic [1:0] mode);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // Mix of rail values, small values and full-range noise
    function automatic logic signed [SAMPLE_WIDTH-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2, 3:    return SAMPLE_WIDTH'($signed($urandom_range(0, 2000)) - 1000);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // Random spectra, short ones among them, until enough samples went in
    task automatic run_spectra(input int min_items);
        int sent;
        int len;
        int i;
        sent = 0;
        while (sent < min_items) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : $urandom_range(10, 24);
            for (i = 0; i < len; i++)
                offer_sample(draw_sample(), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        int i;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset mode (smoothing): single sample spectrum
        offer_sample(SMP_MAX, 1'b1);
        // spectrum shorter than half width plus one
        offer_sample('0, 1'b0);
        offer_sample(SAMPLE_WIDTH'(-1), 1'b0);
        offer_sample(SAMPLE_WIDTH'(1), 1'b1);
        // spectrum of exactly twice the half width passes through
        offer_sample(SMP_MAX, 1'b0);
        offer_sample(SMP_MIN, 1'b0);
        offer_sample('0, 1'b0);
        offer_sample(SAMPLE_WIDTH'(-1), 1'b0);
        offer_sample(SAMPLE_WIDTH'(24'h555555), 1'b0);
        offer_sample(SAMPLE_WIDTH'(24'haaaaaa), 1'b1);
        // rails lined up against the taps to drive saturation
        for (i = 0; i < 13; i++)
            offer_sample((i % 7 == 0 || i % 7 == 6) ? SMP_MIN : SMP_MAX, i == 12);

        set_window_mode(sgw_pkg::MODE_DERIV5);
        flood_phase = 1'b1;
        run_spectra(PHASE_ITEMS);
        set_window_mode(sgw_pkg::MODE_DERIV9);
        run_spectra(PHASE_ITEMS);
        set_window_mode(MODE_SPARE);
        run_spectra(PHASE_ITEMS);
        set_window_mode(sgw_pkg::MODE_SMOOTH7);
        run_spectra(PHASE_ITEMS);

        wait_idle();
        if (mismatch_count == 0)
            $display("savitzky_golay_window_filter verification clean");
        else
            $display("savitzky_golay_window_filter verification failed");
        $finish;
    end

endmodule
